// File: rtl/core/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active low)
`define SSVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define SSVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ssvd_pkg.sv
// Package: item kinds, digit codes, page codes, divider constants and glyph table
`default_nettype none

package ssvd_pkg;

    localparam int DIGIT_COUNT_DEF = 8;

    // s_kind values
    localparam logic KIND_SCAN    = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    typedef logic [4:0] code_t;

    localparam code_t CODE_BLANK   = 5'd10;
    localparam code_t CODE_DP_BASE = 5'd11;
    localparam code_t CODE_C       = 5'd22;
    localparam code_t CODE_L       = 5'd23;
    localparam code_t CODE_P       = 5'd24;
    localparam code_t CODE_N       = 5'd25;

    // {display_mode, page_select}
    localparam logic [2:0] PAGE_TEMP   = 3'b000;
    localparam logic [2:0] PAGE_DIST   = 3'b001;
    localparam logic [2:0] PAGE_COUNT  = 3'b010;
    localparam logic [2:0] PAGE_LIMIT1 = 3'b100;
    localparam logic [2:0] PAGE_LIMIT2 = 3'b101;

    localparam logic [13:0] TEMP_MAX = 14'd9999;
    localparam logic [6:0]  TWO_MAX  = 7'd99;

    // Reciprocals ceil(2^s / d), exact for any 16-bit dividend
    localparam logic [16:0] RECIP_10    = 17'd104858;  // s = 20
    localparam logic [16:0] RECIP_100   = 17'd83887;   // s = 23
    localparam logic [16:0] RECIP_1000  = 17'd67109;   // s = 26
    localparam logic [16:0] RECIP_10000 = 17'd107375;  // s = 30

    // Active-low segment byte, bit 7 is the decimal point
    function automatic logic [7:0] glyph(input code_t code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'hc0;
            5'd1:    seg = 8'hf9;
            5'd2:    seg = 8'ha4;
            5'd3:    seg = 8'hb0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hf8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd11:   seg = 8'h40;
            5'd12:   seg = 8'h79;
            5'd13:   seg = 8'h24;
            5'd14:   seg = 8'h30;
            5'd15:   seg = 8'h19;
            5'd16:   seg = 8'h12;
            5'd17:   seg = 8'h02;
            5'd18:   seg = 8'h78;
            5'd19:   seg = 8'h00;
            5'd20:   seg = 8'h10;
            5'd22:   seg = 8'hc6;
            5'd23:   seg = 8'hc7;
            5'd24:   seg = 8'h8c;
            5'd25:   seg = 8'hc8;
            default: seg = 8'hff;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/seven_segment_value_display.sv
// Top level: multiplexed seven-segment driver with page formatter
//
// Usage
//   Input channel (s_valid/s_ready) carries one item per transfer. s_kind = 1 is a
//   refresh: the selected page is formatted into the eight-entry digit buffer and
//   nothing comes out. s_kind = 0 is a scan tick: the current digit's one-hot select
//   and active-low segment byte come out on the m_ channel, then the scan position
//   steps, wrapping after DIGIT_COUNT positions.
//   Path: an item is first held in the input register; a scan tick's result is then
//   loaded into the output register, which drives the m_ channel.
//   Throughput: one item per cycle while no scan tick stalls, set by the single input
//   and output register stages; a refresh never waits on the output side.
//   Stall: while m_valid is high and m_ready low, the output register holds, and a
//   scan tick waiting in the input register holds and keeps s_ready low. A refresh
//   in the input register still retires, since it needs no output slot.
//   Reset (aresetn low, synchronous): buffer becomes all blank, scan position 0,
//   both registers empty. No clearing pass is needed.
//   Invalid mode/page pairs leave the buffer unchanged.
`default_nettype none

module seven_segment_value_display #(
    parameter int DIGIT_COUNT = ssvd_pkg::DIGIT_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_display_mode,
    input  wire logic [1:0]  s_page_select,
    input  wire logic [13:0] s_temperature_centi,
    input  wire logic [6:0]  s_distance_value,
    input  wire logic [15:0] s_change_count,
    input  wire logic [6:0]  s_temperature_limit,
    input  wire logic [6:0]  s_distance_limit,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [7:0]  m_digit_select,
    output      logic [7:0]  m_segment_pattern
);

    localparam logic [2:0] LAST_POS = 3'(DIGIT_COUNT - 1);

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [2:0]  in_page_reg;
    logic [13:0] in_temp_reg;
    logic [6:0]  in_dist_reg;
    logic [15:0] in_count_reg;
    logic [6:0]  in_tlim_reg;
    logic [6:0]  in_dlim_reg;

    // ---------------- state ----------------
    ssvd_pkg::code_t digit_codes_reg [8];
    ssvd_pkg::code_t digit_codes_next [8];
    logic [2:0]      scan_pos_reg;
    logic [2:0]      scan_pos_next;

    // ---------------- output register ----------------
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_select_reg;
    logic [7:0] m_select_next;
    logic [7:0] m_segment_reg;
    logic [7:0] m_segment_next;

    logic advance;
    logic do_scan;
    logic do_refresh;

    // an item retires when it is a refresh or the output slot is free
    assign advance    = in_valid_reg && (in_kind_reg || !m_valid_reg || m_ready);
    assign do_scan    = advance && !in_kind_reg;
    assign do_refresh = advance && in_kind_reg;
    assign s_ready    = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_page_reg  <= {s_display_mode, s_page_select};
            in_temp_reg  <= s_temperature_centi;
            in_dist_reg  <= s_distance_value;
            in_count_reg <= s_change_count;
            in_tlim_reg  <= s_temperature_limit;
            in_dlim_reg  <= s_distance_limit;
        end
    end

    // ---------------- value select and saturation ----------------
    logic [15:0] fmt_value;
    logic [13:0] temp_sat;
    logic [6:0]  dist_sat;
    logic [6:0]  tlim_sat;
    logic [6:0]  dlim_sat;

    assign temp_sat = (in_temp_reg > ssvd_pkg::TEMP_MAX) ? ssvd_pkg::TEMP_MAX : in_temp_reg;
    assign dist_sat = (in_dist_reg > ssvd_pkg::TWO_MAX) ? ssvd_pkg::TWO_MAX : in_dist_reg;
    assign tlim_sat = (in_tlim_reg > ssvd_pkg::TWO_MAX) ? ssvd_pkg::TWO_MAX : in_tlim_reg;
    assign dlim_sat = (in_dlim_reg > ssvd_pkg::TWO_MAX) ? ssvd_pkg::TWO_MAX : in_dlim_reg;

    always_comb begin
        case (in_page_reg)
            ssvd_pkg::PAGE_TEMP:   fmt_value = 16'(temp_sat);
            ssvd_pkg::PAGE_DIST:   fmt_value = 16'(dist_sat);
            ssvd_pkg::PAGE_COUNT:  fmt_value = in_count_reg;
            ssvd_pkg::PAGE_LIMIT1: fmt_value = 16'(tlim_sat);
            ssvd_pkg::PAGE_LIMIT2: fmt_value = 16'(dlim_sat);
            default:               fmt_value = in_count_reg;
        endcase
    end

    // ---------------- decimal split ----------------
    // Each quotient v / 10^k comes from its own reciprocal multiply; digits are
    // then q_k - 10 * q_(k+1), with the times-ten done as shift and add.
    logic [32:0] prod_10;
    logic [32:0] prod_100;
    logic [32:0] prod_1000;
    logic [32:0] prod_10000;
    logic [12:0] q1;
    logic [9:0]  q2;
    logic [6:0]  q3;
    logic [2:0]  q4;
    logic [3:0]  dig0;
    logic [3:0]  dig1;
    logic [3:0]  dig2;
    logic [3:0]  dig3;

    assign prod_10    = 33'(fmt_value) * 33'(ssvd_pkg::RECIP_10);
    assign prod_100   = 33'(fmt_value) * 33'(ssvd_pkg::RECIP_100);
    assign prod_1000  = 33'(fmt_value) * 33'(ssvd_pkg::RECIP_1000);
    assign prod_10000 = 33'(fmt_value) * 33'(ssvd_pkg::RECIP_10000);

    assign q1 = prod_10[32:20];
    assign q2 = prod_100[32:23];
    assign q3 = prod_1000[32:26];
    assign q4 = prod_10000[32:30];

    // the remainder is below ten, so four low bits of the difference suffice
    assign dig0 = fmt_value[3:0] - (4'(q1) << 3) - (4'(q1) << 1);
    assign dig1 = 4'(q1) - (4'(q2) << 3) - (4'(q2) << 1);
    assign dig2 = 4'(q2) - (4'(q3) << 3) - (4'(q3) << 1);
    assign dig3 = 4'(q3) - (4'(q4) << 3) - (4'(q4) << 1);

    // ---------------- buffer update ----------------
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digit_codes_next[i] = digit_codes_reg[i];
        end
        if (do_refresh) begin
            case (in_page_reg)
                ssvd_pkg::PAGE_TEMP: begin
                    for (int i = 1; i < 8; i++) begin
                        digit_codes_next[i] = ssvd_pkg::CODE_BLANK;
                    end
                    digit_codes_next[0] = ssvd_pkg::CODE_C;
                    digit_codes_next[4] = {1'b0, dig3};
                    digit_codes_next[5] = {1'b0, dig2} + ssvd_pkg::CODE_DP_BASE;
                    digit_codes_next[6] = {1'b0, dig1};
                    digit_codes_next[7] = {1'b0, dig0};
                end
                ssvd_pkg::PAGE_DIST: begin
                    for (int i = 1; i < 8; i++) begin
                        digit_codes_next[i] = ssvd_pkg::CODE_BLANK;
                    end
                    digit_codes_next[0] = ssvd_pkg::CODE_L;
                    digit_codes_next[6] = {1'b0, dig1};
                    digit_codes_next[7] = {1'b0, dig0};
                end
                ssvd_pkg::PAGE_COUNT: begin
                    for (int i = 1; i < 8; i++) begin
                        digit_codes_next[i] = ssvd_pkg::CODE_BLANK;
                    end
                    digit_codes_next[0] = ssvd_pkg::CODE_N;
                    // leading blanks: a digit shows once its own quotient is nonzero
                    digit_codes_next[3] = (q4 != 3'd0) ? {2'b00, q4} : ssvd_pkg::CODE_BLANK;
                    digit_codes_next[4] = (q3 != 7'd0) ? {1'b0, dig3} : ssvd_pkg::CODE_BLANK;
                    digit_codes_next[5] = (q2 != 10'd0) ? {1'b0, dig2} : ssvd_pkg::CODE_BLANK;
                    digit_codes_next[6] = (q1 != 13'd0) ? {1'b0, dig1} : ssvd_pkg::CODE_BLANK;
                    digit_codes_next[7] = {1'b0, dig0};
                end
                ssvd_pkg::PAGE_LIMIT1: begin
                    for (int i = 1; i < 8; i++) begin
                        digit_codes_next[i] = ssvd_pkg::CODE_BLANK;
                    end
                    digit_codes_next[0] = ssvd_pkg::CODE_P;
                    digit_codes_next[3] = 5'd1;
                    digit_codes_next[6] = {1'b0, dig1};
                    digit_codes_next[7] = {1'b0, dig0};
                end
                ssvd_pkg::PAGE_LIMIT2: begin
                    for (int i = 1; i < 8; i++) begin
                        digit_codes_next[i] = ssvd_pkg::CODE_BLANK;
                    end
                    digit_codes_next[0] = ssvd_pkg::CODE_P;
                    digit_codes_next[3] = 5'd2;
                    digit_codes_next[6] = {1'b0, dig1};
                    digit_codes_next[7] = {1'b0, dig0};
                end
                default: begin
                    // no such page: buffer keeps its contents
                end
            endcase
        end
    end

    // ---------------- scan and output register ----------------
    always_comb begin
        scan_pos_next  = scan_pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_select_next  = m_select_reg;
        m_segment_next = m_segment_reg;
        if (do_scan) begin
            scan_pos_next  = (scan_pos_reg == LAST_POS) ? 3'd0 : scan_pos_reg + 3'd1;
            m_valid_next   = 1'b1;
            m_select_next  = 8'd1 << scan_pos_reg;
            m_segment_next = ssvd_pkg::glyph(digit_codes_reg[scan_pos_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                digit_codes_reg[i] <= ssvd_pkg::CODE_BLANK;
            end
            scan_pos_reg <= 3'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            for (int i = 0; i < 8; i++) begin
                digit_codes_reg[i] <= digit_codes_next[i];
            end
            scan_pos_reg <= scan_pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_select_reg  <= m_select_next;
        m_segment_reg <= m_segment_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_digit_select    = m_select_reg;
    assign m_segment_pattern = m_segment_reg;

endmodule

`default_nettype wire

// File: rtl/core/ssvd_checker.sv
// Port-level checker for the seven-segment driver, with its bind
`default_nettype none

`include "assert_macros.svh"

module ssvd_port_checker #(
    parameter int DIGIT_COUNT = ssvd_pkg::DIGIT_COUNT_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_kind,
    input wire logic        s_display_mode,
    input wire logic [1:0]  s_page_select,
    input wire logic [13:0] s_temperature_centi,
    input wire logic [6:0]  s_distance_value,
    input wire logic [15:0] s_change_count,
    input wire logic [6:0]  s_temperature_limit,
    input wire logic [6:0]  s_distance_limit,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_digit_select,
    input wire logic [7:0]  m_segment_pattern
);

    logic [15:0] sel_wide;
    logic [15:0] m_out;
    logic        stalled;

    assign sel_wide = {8'd0, m_digit_select} >> DIGIT_COUNT;
    assign m_out    = {m_digit_select, m_segment_pattern};
    assign stalled  = m_valid && !m_ready;

    // reset empties the output register
    `SSVD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // exactly one digit enabled per transfer
    `SSVD_ASSERT(a_onehot, aclk, aresetn, m_valid |-> $onehot(m_digit_select), "not one-hot")

    // positions past DIGIT_COUNT are never driven
    `SSVD_ASSERT(a_range, aclk, aresetn, m_valid |-> (sel_wide == 16'd0), "select out of range")

    // stalled result holds
    `SSVD_ASSERT(a_hold, aclk, aresetn, stalled |=> m_valid && $stable(m_out), "output not held")

endmodule

bind seven_segment_value_display ssvd_port_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_ssvd_port_checker (.*);

`default_nettype wire

// File: dv/ssvd_checker.sv
// Checker: predicts every scan transfer of the display driver and compares the results
`timescale 1ns / 100ps

module ssvd_checker #(
    parameter int DIGIT_COUNT = ssvd_pkg::DIGIT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic        s_display_mode,
    input  logic [1:0]  s_page_select,
    input  logic [13:0] s_temperature_centi,
    input  logic [6:0]  s_distance_value,
    input  logic [15:0] s_change_count,
    input  logic [6:0]  s_temperature_limit,
    input  logic [6:0]  s_distance_limit,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_digit_select,
    input  logic [7:0]  m_segment_pattern,
    output int          fail_count,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] SEG_BLANK = 8'hff;
    localparam logic [7:0] SEG_DP    = 8'h80;
    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic [7:0] select;
        logic [7:0] segments;
    } scan_out_t;

    ssvd_pkg::code_t digit_buf [8];
    int              scan_pos;
    scan_out_t       expected_scans [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // active-low segment byte of one digit code
    function automatic logic [7:0] segments_of(input ssvd_pkg::code_t code);
        if (code < ssvd_pkg::CODE_BLANK)
            return DIGIT_GLYPH[code];
        if (code >= ssvd_pkg::CODE_DP_BASE && code < ssvd_pkg::CODE_DP_BASE + 5'd10)
            return DIGIT_GLYPH[code - ssvd_pkg::CODE_DP_BASE] & ~SEG_DP;
        case (code)
            ssvd_pkg::CODE_C: return 8'hc6;
            ssvd_pkg::CODE_L: return 8'hc7;
            ssvd_pkg::CODE_P: return 8'h8c;
            ssvd_pkg::CODE_N: return 8'hc8;
            default:          return SEG_BLANK;
        endcase
    endfunction

    function automatic int unsigned clamp_two(input logic [6:0] v);
        return 32'((v > ssvd_pkg::TWO_MAX) ? ssvd_pkg::TWO_MAX : v);
    endfunction

    task automatic blank_frame(input ssvd_pkg::code_t label);
        digit_buf[0] = label;
        for (int i = 1; i < 8; i++) digit_buf[i] = ssvd_pkg::CODE_BLANK;
    endtask

    task automatic put_two(input int unsigned v);
        digit_buf[6] = ssvd_pkg::code_t'(v / 10);
        digit_buf[7] = ssvd_pkg::code_t'(v % 10);
    endtask

    // rewrite the digit buffer from the refresh transfer on the input ports
    task automatic format_page();
        int unsigned v;
        case ({s_display_mode, s_page_select})
            ssvd_pkg::PAGE_TEMP: begin
                v = 32'((s_temperature_centi > ssvd_pkg::TEMP_MAX) ? ssvd_pkg::TEMP_MAX
                                                                     : s_temperature_centi);
                blank_frame(ssvd_pkg::CODE_C);
                digit_buf[4] = ssvd_pkg::code_t'(v / 1000);
                digit_buf[5] = ssvd_pkg::code_t'(v / 100 % 10) + ssvd_pkg::CODE_DP_BASE;
                digit_buf[6] = ssvd_pkg::code_t'(v / 10 % 10);
                digit_buf[7] = ssvd_pkg::code_t'(v % 10);
            end
            ssvd_pkg::PAGE_DIST: begin
                blank_frame(ssvd_pkg::CODE_L);
                put_two(clamp_two(s_distance_value));
            end
            ssvd_pkg::PAGE_COUNT: begin
                v = 32'(s_change_count);
                blank_frame(ssvd_pkg::CODE_N);
                digit_buf[3] = (v >= 10000) ? ssvd_pkg::code_t'(v / 10000)
                                            : ssvd_pkg::CODE_BLANK;
                digit_buf[4] = (v >= 1000)  ? ssvd_pkg::code_t'(v / 1000 % 10)
                                            : ssvd_pkg::CODE_BLANK;
                digit_buf[5] = (v >= 100)   ? ssvd_pkg::code_t'(v / 100 % 10)
                                            : ssvd_pkg::CODE_BLANK;
                digit_buf[6] = (v >= 10)    ? ssvd_pkg::code_t'(v / 10 % 10)
                                            : ssvd_pkg::CODE_BLANK;
                digit_buf[7] = ssvd_pkg::code_t'(v % 10);
            end
            ssvd_pkg::PAGE_LIMIT1: begin
                blank_frame(ssvd_pkg::CODE_P);
                digit_buf[3] = ssvd_pkg::code_t'(1);
                put_two(clamp_two(s_temperature_limit));
            end
            ssvd_pkg::PAGE_LIMIT2: begin
                blank_frame(ssvd_pkg::CODE_P);
                digit_buf[3] = ssvd_pkg::code_t'(2);
                put_two(clamp_two(s_distance_limit));
            end
            default: ;  // no such page: buffer kept
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %02h, got %02h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        scan_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) digit_buf[i] = ssvd_pkg::CODE_BLANK;
            scan_pos = 0;
            expected_scans.delete();
        end else begin
            // results leave before this edge's input is modeled
            if (m_valid && m_ready) begin
                if (expected_scans.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with none expected, select %02h segments %02h",
                                 $realtime, m_digit_select, m_segment_pattern);
                end else begin
                    want = expected_scans.pop_front();
                    if (m_digit_select !== want.select)
                        note_mismatch("digit_select", want.select, m_digit_select);
                    if (m_segment_pattern !== want.segments)
                        note_mismatch("segment_pattern", want.segments, m_segment_pattern);
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == ssvd_pkg::KIND_REFRESH) begin
                    format_page();
                end else begin
                    want.select   = 8'(1 << scan_pos);
                    want.segments = segments_of(digit_buf[scan_pos]);
                    expected_scans.push_back(want);
                    scan_pos = (scan_pos + 1 >= DIGIT_COUNT) ? 0 : scan_pos + 1;
                end
            end
        end
        pending = expected_scans.size();
    end

endmodule

// File: dv/testbench.sv
// Testbench top: drives refresh and scan transfers into the display driver
`timescale 1ns / 100ps

module testbench;

    localparam int DIGITS        = ssvd_pkg::DIGIT_COUNT_DEF;
    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 12;

    // {display_mode, page_select} pairs that have no page
    localparam logic [2:0] NO_PAGES [3]    = '{3'b011, 3'b110, 3'b111};
    localparam logic [2:0] VALID_PAGES [5] =
        '{ssvd_pkg::PAGE_TEMP, ssvd_pkg::PAGE_DIST, ssvd_pkg::PAGE_COUNT,
          ssvd_pkg::PAGE_LIMIT1, ssvd_pkg::PAGE_LIMIT2};
    // counts around the leading-blank thresholds
    localparam int unsigned COUNT_STEPS [8] = '{9, 10, 99, 100, 999, 1000, 9999, 10000};

    typedef struct {
        logic        kind;
        logic        mode;
        logic [1:0]  page;
        logic [13:0] temp;
        logic [6:0]  dval;
        logic [15:0] count;
        logic [6:0]  tlim;
        logic [6:0]  dlim;
    } display_item_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CYCLIC} ready_style_t;

    // every block input starts at a known value
    logic        aclk                = 1'b0;
    logic        aresetn             = 1'b0;
    logic        s_valid             = 1'b0;
    logic        s_kind              = ssvd_pkg::KIND_SCAN;
    logic        s_display_mode      = 1'b0;
    logic [1:0]  s_page_select       = '0;
    logic [13:0] s_temperature_centi = '0;
    logic [6:0]  s_distance_value    = '0;
    logic [15:0] s_change_count      = '0;
    logic [6:0]  s_temperature_limit = '0;
    logic [6:0]  s_distance_limit    = '0;
    logic        m_ready             = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_digit_select;
    logic [7:0]  m_segment_pattern;

    int fail_count;
    int pending;

    // sender bookkeeping
    int burst_left    = 1;
    int refresh_xfers = 0;
    int scan_xfers    = 0;
    int counted       = 0;

    // receiver stall pattern
    ready_style_t ready_style = READY_ALWAYS;
    int           style_left  = 0;
    int           ready_tick  = 0;

    always #6 aclk = ~aclk;

    seven_segment_value_display #(
        .DIGIT_COUNT(DIGITS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_display_mode     (s_display_mode),
        .s_page_select      (s_page_select),
        .s_temperature_centi(s_temperature_centi),
        .s_distance_value   (s_distance_value),
        .s_change_count     (s_change_count),
        .s_temperature_limit(s_temperature_limit),
        .s_distance_limit   (s_distance_limit),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_digit_select     (m_digit_select),
        .m_segment_pattern  (m_segment_pattern)
    );

    ssvd_checker #(
        .DIGIT_COUNT(DIGITS)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_display_mode     (s_display_mode),
        .s_page_select      (s_page_select),
        .s_temperature_centi(s_temperature_centi),
        .s_distance_value   (s_distance_value),
        .s_change_count     (s_change_count),
        .s_temperature_limit(s_temperature_limit),
        .s_distance_limit   (s_distance_limit),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_digit_select     (m_digit_select),
        .m_segment_pattern  (m_segment_pattern),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // Receiver: switches between randomly picked stall styles, so that
    // stretches of full throughput alternate with heavy back-pressure.
    always @(negedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (style_left == 0) begin
            ready_style <= ready_style_t'($urandom_range(0, 3));
            style_left  <= $urandom_range(30, 150);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:      m_ready <= (ready_tick % 5) != 0;
        endcase
    end

    // all payload bits random; fields the item does not use are left as noise
    function automatic display_item_t noise_item();
        display_item_t it;
        it.kind  = 1'($urandom_range(0, 1));
        it.mode  = 1'($urandom_range(0, 1));
        it.page  = 2'($urandom_range(0, 3));
        it.temp  = 14'($urandom);
        it.dval  = 7'($urandom);
        it.count = 16'($urandom);
        it.tlim  = 7'($urandom);
        it.dlim  = 7'($urandom);
        return it;
    endfunction

    function automatic display_item_t scan_item();
        display_item_t it;
        it      = noise_item();
        it.kind = ssvd_pkg::KIND_SCAN;
        return it;
    endfunction

    // refresh of one page, val lands in the field that page shows
    function automatic display_item_t make_refresh(input logic [2:0] page_code,
                                                   input int unsigned val);
        display_item_t it;
        it               = noise_item();
        it.kind          = ssvd_pkg::KIND_REFRESH;
        {it.mode, it.page} = page_code;
        case (page_code)
            ssvd_pkg::PAGE_TEMP:   it.temp  = 14'(val);
            ssvd_pkg::PAGE_DIST:   it.dval  = 7'(val);
            ssvd_pkg::PAGE_COUNT:  it.count = 16'(val);
            ssvd_pkg::PAGE_LIMIT1: it.tlim  = 7'(val);
            ssvd_pkg::PAGE_LIMIT2: it.dlim  = 7'(val);
            default: ;
        endcase
        return it;
    endfunction

    // leans on zero, the top of range, just above it and the field maximum
    function automatic int unsigned pick_value(input int unsigned top, input int unsigned full);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return top;
            2:       return (top < full) ? top + 1 : top;
            3:       return full;
            default: return $urandom_range(0, full);
        endcase
    endfunction

    function automatic int unsigned value_for(input logic [2:0] page_code);
        case (page_code)
            ssvd_pkg::PAGE_TEMP:  return pick_value(32'(ssvd_pkg::TEMP_MAX), 16383);
            ssvd_pkg::PAGE_COUNT: begin
                if ($urandom_range(0, 2) == 0)
                    return COUNT_STEPS[$urandom_range(0, 7)];
                return pick_value(65535, 65535);
            end
            default:              return pick_value(32'(ssvd_pkg::TWO_MAX), 127);
        endcase
    endfunction

    // One transfer. Valid stays high across back-to-back items of a burst;
    // at the end of a burst the sender may drop valid for a random gap.
    task automatic send(input display_item_t it);
        int gap;
        @(negedge aclk);
        s_valid             <= 1'b1;
        s_kind              <= it.kind;
        s_display_mode      <= it.mode;
        s_page_select       <= it.page;
        s_temperature_centi <= it.temp;
        s_distance_value    <= it.dval;
        s_change_count      <= it.count;
        s_temperature_limit <= it.tlim;
        s_distance_limit    <= it.dlim;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == ssvd_pkg::KIND_SCAN)
            scan_xfers++;
        else
            refresh_xfers++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic scans(input int n);
        repeat (n) send(scan_item());
    endtask

    initial begin
        int           pick;
        int           n;
        logic [2:0]   pg;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: blank buffer after reset, saturated temperature with the
        // decimal point, the three pairs with no page leaving the buffer alone
        // (seen over a full wrap of the scan), then the other page extremes.
        scans(3);
        send(make_refresh(ssvd_pkg::PAGE_TEMP, 16383));
        scans(5);
        foreach (NO_PAGES[i]) send(make_refresh(NO_PAGES[i], 0));
        scans(DIGITS);
        send(make_refresh(ssvd_pkg::PAGE_COUNT, 10000));
        send(make_refresh(ssvd_pkg::PAGE_DIST, 127));
        send(make_refresh(ssvd_pkg::PAGE_LIMIT2, 127));

        // Random: mostly a refresh of a real page followed by a sweep of the
        // scan, plus refreshes of missing pages and stray scan runs.
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pg = VALID_PAGES[$urandom_range(0, 4)];
                send(make_refresh(pg, value_for(pg)));
                n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : DIGITS;
                scans(n);
                counted += n + 1;
            end else if (pick < 8) begin
                send(make_refresh(NO_PAGES[$urandom_range(0, 2)], $urandom));
            end else begin
                n = $urandom_range(1, 5);
                scans(n);
                counted += n;
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain: every predicted scan result must come out
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d refresh and %0d scan transfers over all five pages,",
                 refresh_xfers, scan_xfers);
        $display("missing pages, saturation and leading-blank boundaries included.");
        if (fail_count == 0 && pending == 0) begin
            $display("[seven_segment_value_display] OK");
        end else begin
            $display("[seven_segment_value_display] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("[seven_segment_value_display] ERROR");
        $finish;
    end

endmodule
